### sv/afd_pkg.sv
// Shared types and constants for the allpass delay filter.
`timescale 1ns / 1ps

package afd_pkg;

	// Delay memory depth and stored word width
	localparam int MAX_DELAY_SAMPLES = 262144;
	localparam int STORE_WIDTH       = 24;
	localparam int ADDR_W            = $clog2(MAX_DELAY_SAMPLES);

	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 18;
	localparam int DECAY_W  = 7;
	localparam int CFG_W    = 18;
	localparam int CFG_IDX_W = 2;
	localparam int SUM_W    = STORE_WIDTH + 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_PERCENT = 2'd1;

	localparam logic [DELAY_W-1:0] DELAY_RESET    = 18'd176179;
	localparam logic [DELAY_W-1:0] DELAY_FALLBACK = DELAY_W'(MAX_DELAY_SAMPLES / 2);
	localparam logic [DECAY_W-1:0] DECAY_RESET    = 7'd50;
	localparam logic [DECAY_W-1:0] DECAY_LIMIT    = 7'd100;
	localparam logic [DECAY_W-1:0] DECAY_FALLBACK = 7'd50;

	// Output limit: +/-0.9999 in Q1.15
	localparam logic signed [SAMPLE_W-1:0] OUT_POS_LIMIT = 16'sd32764;
	localparam logic signed [SAMPLE_W-1:0] OUT_NEG_LIMIT = -16'sd32764;

	// Gain x*decay/100: |x|*decay + 50, drop two bits, then times a reciprocal of 25
	localparam int PROD_W      = STORE_WIDTH + DECAY_W;
	localparam int QN_W        = PROD_W - 2;
	localparam int RECIP_SHIFT = QN_W + 5;
	localparam int RECIP_W     = QN_W + 1;
	localparam logic [RECIP_W-1:0] RECIP_25 =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25);
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(50);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Request passed from the front to the back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [ADDR_W-1:0]          addr;
		logic                       fill;
	} afd_req_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_READ,
		BK_GD_WAIT,
		BK_GD,
		BK_GS_LOAD,
		BK_GS_WAIT,
		BK_GS,
		BK_GX_WAIT,
		BK_GX,
		BK_OUT
	} back_state_t;

endpackage

### sv/afd_front.sv
// Front end: configuration registers, request intake and fill/steady classification.
`timescale 1ns / 1ps

module afd_front import afd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       q_full,
	output logic                       q_push,
	output afd_req_t                   q_req,
	output logic [DECAY_W-1:0]         decay
);

	logic [DELAY_W-1:0] delay_q;
	logic [DECAY_W-1:0] decay_q;
	logic [DELAY_W-1:0] wr_idx_q;
	logic [DELAY_W-1:0] fill_cnt_q;

	logic [DELAY_W-1:0] dlen;
	logic [DELAY_W:0]   idx_inc;
	logic [DELAY_W-1:0] idx_next;
	logic               is_fill;
	logic [DELAY_W-1:0] cfg_delay;
	logic [DECAY_W-1:0] cfg_decay;

	assign dlen     = (delay_q == '0) ? DELAY_W'(1) : delay_q;
	assign is_fill  = fill_cnt_q < dlen;
	assign idx_inc  = {1'b0, wr_idx_q} + (DELAY_W+1)'(1);
	assign idx_next = (idx_inc >= {1'b0, dlen}) ? '0 : idx_inc[DELAY_W-1:0];

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	assign q_req.sample = sample_in;
	assign q_req.addr   = ADDR_W'(wr_idx_q);
	assign q_req.fill   = is_fill;
	assign decay        = decay_q;

	always_comb begin
		cfg_delay = cfg_wdata[DELAY_W-1:0];
		if (32'(cfg_delay) > 32'(MAX_DELAY_SAMPLES - 2)) begin
			cfg_delay = DELAY_FALLBACK;
		end
		cfg_decay = cfg_wdata[DECAY_W-1:0];
		if (cfg_decay >= DECAY_LIMIT) begin
			cfg_decay = DECAY_FALLBACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= DELAY_RESET;
			decay_q    <= DECAY_RESET;
			wr_idx_q   <= '0;
			fill_cnt_q <= '0;
		end else if (cfg_we && (cfg_idx == REG_DELAY_SAMPLES || cfg_idx == REG_DECAY_PERCENT)) begin
			if (cfg_idx == REG_DELAY_SAMPLES) begin
				delay_q <= cfg_delay;
			end else begin
				decay_q <= cfg_decay;
			end
			wr_idx_q   <= '0;
			fill_cnt_q <= '0;
		end else if (q_push) begin
			wr_idx_q <= idx_next;
			if (is_fill) begin
				fill_cnt_q <= fill_cnt_q + DELAY_W'(1);
			end
		end
	end

endmodule

### sv/afd_fifo.sv
// Short request queue between the front and the back.
`timescale 1ns / 1ps

module afd_fifo import afd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  afd_req_t req_in,
	output logic     full,
	input  logic     pop,
	output afd_req_t req_out,
	output logic     empty
);

	afd_req_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign req_out = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

### sv/afd_gain.sv
// Two-stage gain multiplier: value * decay / 100, rounded half away from zero.
`timescale 1ns / 1ps

module afd_gain import afd_pkg::*; (
	input  logic                          clk,
	input  logic signed [STORE_WIDTH-1:0] value,
	input  logic [DECAY_W-1:0]            decay,
	output logic signed [STORE_WIDTH-1:0] result
);

	logic [STORE_WIDTH-1:0]        mag;
	logic [PROD_W-1:0]             num_s1;
	logic                          neg_s1;
	logic [QN_W+RECIP_W-1:0]       prod_s2;
	logic                          neg_s2;
	logic [STORE_WIDTH-1:0]        quot;

	assign mag = value[STORE_WIDTH-1] ? STORE_WIDTH'(-value) : STORE_WIDTH'(value);

	always_ff @(posedge clk) begin
		num_s1  <= PROD_W'(mag) * PROD_W'(decay) + ROUND_HALF;
		neg_s1  <= value[STORE_WIDTH-1];
		// floor(n/100) = floor((n>>2)/25), exact by the reciprocal for this range
		prod_s2 <= (QN_W+RECIP_W)'(num_s1[PROD_W-1:2]) * (QN_W+RECIP_W)'(RECIP_25);
		neg_s2  <= neg_s1;
	end

	assign quot   = prod_s2[RECIP_SHIFT +: STORE_WIDTH];
	assign result = neg_s2 ? -$signed(quot) : $signed(quot);

endmodule

### sv/afd_back.sv
// Back end: delay memory, allpass arithmetic sequencer and output register.
`timescale 1ns / 1ps

module afd_back import afd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  afd_req_t                    req,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  logic [DECAY_W-1:0]          decay,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [SAMPLE_W-1:0]  sample_out
);

	localparam logic signed [SUM_W-1:0] LIM_POS   = SUM_W'(32768);
	localparam logic signed [SUM_W-1:0] LIM_NEG   = -LIM_POS;
	localparam logic signed [SUM_W-1:0] STORE_MAX = SUM_W'({1'b0, {(STORE_WIDTH-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] STORE_MIN = -STORE_MAX - SUM_W'(1);

	logic [STORE_WIDTH-1:0] mem_q [MAX_DELAY_SAMPLES];
	logic [STORE_WIDTH-1:0] rd_data_q;

	back_state_t                 state_q, state_d;
	logic signed [SAMPLE_W-1:0]  x_q;
	logic [ADDR_W-1:0]           addr_q;
	logic signed [STORE_WIDTH-1:0] s_q;
	logic signed [SAMPLE_W-1:0]  y_q;
	logic                        out_valid_q;
	logic signed [SAMPLE_W-1:0]  out_sample_q;

	logic                          mem_we;
	logic                          mem_re;
	logic [ADDR_W-1:0]             mem_addr;
	logic [STORE_WIDTH-1:0]        mem_wdata;
	logic signed [STORE_WIDTH-1:0] gain_in;
	logic signed [STORE_WIDTH-1:0] gain_out;
	logic signed [SUM_W-1:0]       sum;
	logic signed [STORE_WIDTH-1:0] s_sat;
	logic                          s_load;
	logic signed [SUM_W-1:0]       y_full;
	logic                          y_load;
	logic                          out_load;

	function automatic logic signed [SAMPLE_W-1:0] out_limit(input logic signed [SUM_W-1:0] y);
		logic signed [SAMPLE_W-1:0] r;
		if (y >= LIM_POS) begin
			r = OUT_POS_LIMIT;
		end else if (y <= LIM_NEG) begin
			r = OUT_NEG_LIMIT;
		end else begin
			r = y[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	afd_gain u_gain (
		.clk    (clk),
		.value  (gain_in),
		.decay  (decay),
		.result (gain_out)
	);

	// s = x + g*d, saturated to the stored width
	assign sum = SUM_W'(x_q) + SUM_W'(gain_out);
	always_comb begin
		if (sum > STORE_MAX) begin
			s_sat = STORE_MAX[STORE_WIDTH-1:0];
		end else if (sum < STORE_MIN) begin
			s_sat = STORE_MIN[STORE_WIDTH-1:0];
		end else begin
			s_sat = sum[STORE_WIDTH-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = STORE_WIDTH'(s_sat);
		gain_in   = '0;
		s_load    = 1'b0;
		y_full    = '0;
		y_load    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				mem_addr  = req.addr;
				mem_wdata = STORE_WIDTH'(req.sample);
				gain_in   = STORE_WIDTH'(req.sample);
				if (!q_empty) begin
					q_pop = 1'b1;
					if (req.fill) begin
						mem_we  = 1'b1;
						state_d = BK_GX_WAIT;
					end else begin
						mem_re  = 1'b1;
						state_d = BK_READ;
					end
				end
			end
			BK_READ: begin
				gain_in = $signed(rd_data_q);
				state_d = BK_GD_WAIT;
			end
			BK_GD_WAIT: begin
				state_d = BK_GD;
			end
			BK_GD: begin
				mem_we  = 1'b1;
				s_load  = 1'b1;
				state_d = BK_GS_LOAD;
			end
			// stored sum comes from a register so the sum does not chain into the multiplier
			BK_GS_LOAD: begin
				gain_in = s_q;
				state_d = BK_GS_WAIT;
			end
			BK_GS_WAIT: begin
				state_d = BK_GS;
			end
			BK_GS: begin
				y_full  = SUM_W'($signed(rd_data_q)) - SUM_W'(gain_out);
				y_load  = 1'b1;
				state_d = BK_OUT;
			end
			BK_GX_WAIT: begin
				state_d = BK_GX;
			end
			BK_GX: begin
				y_full  = -SUM_W'(gain_out);
				y_load  = 1'b1;
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_q    <= req.sample;
			addr_q <= req.addr;
		end
		if (s_load) begin
			s_q <= s_sat;
		end
		if (y_load) begin
			y_q <= out_limit(y_full);
		end
		if (out_load) begin
			out_sample_q <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_sample_q;

endmodule

### sv/allpass_delay_filter_top.sv
// Allpass delay filter: Schroeder allpass on a Q1.15 sample stream, top level.
// A sample request that finds the delay line still filling needs, in the back end,
// one memory write and one pass through the two-stage gain multiplier; a request
// after the fill phase needs a registered read of the delay memory, then two
// dependent passes through the shared gain multiplier, with the stored sum
// registered between them. Up to four requests queue in front of the back end,
// and a finished result waits in the output register. Gain is
// decay_percent/100 and the delay is delay_samples (0 acts as 1); every write to
// either register restarts the fill phase, writes to other indexes are ignored. The
// delay memory is not cleared after reset: the fill phase writes each entry before it
// is read.
`timescale 1ns / 1ps

module allpass_delay_filter_top import afd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_idx,
	input  logic [CFG_W-1:0]            cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [SAMPLE_W-1:0]  sample_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [SAMPLE_W-1:0]  sample_out
);

	afd_req_t           push_req;
	afd_req_t           head_req;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	logic [DECAY_W-1:0] decay;

	afd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_req     (push_req),
		.decay     (decay)
	);

	afd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.req_in  (push_req),
		.full    (q_full),
		.pop     (q_pop),
		.req_out (head_req),
		.empty   (q_empty)
	);

	afd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (head_req),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.decay      (decay),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

endmodule
